/* rtl/hpwp_pkg.sv */
// ----------------------------------------------------------------------------
// hpwp_pkg
// Shared types and constants of the hit packet word parser.
// ----------------------------------------------------------------------------
package hpwp_pkg;

  localparam int WORD_W    = 64;
  localparam int CHANNEL_W = 8;
  localparam int LEVEL_W   = 16;
  localparam int INDEX_W   = 8;
  localparam int VALUE_W   = 16;
  localparam int TIME_W    = 32;
  localparam int VERSION_W = 8;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 8;

  localparam int DEF_HIT_COUNT_BITS = 8;
  localparam int DEF_MAGIC_BITS     = 8;
  localparam int DEF_TIME_BITS      = 32;
  localparam int DEF_LEVEL_BITS     = 16;
  localparam int DEF_CHANNEL_BITS   = 8;
  localparam int DEF_POINT_BITS     = 16;

  localparam int MAGIC_FIRST  = 171;
  localparam int MAGIC_SECOND = 172;
  localparam int GOOD_POINTS  = 8;

  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_GOOD      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_MAGIC = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT = 2'd2;

  typedef enum logic [3:0] {
    PH_W0        = 4'd0,
    PH_W1        = 4'd1,
    PH_W2        = 4'd2,
    PH_W3        = 4'd3,
    PH_HA        = 4'd4,
    PH_HB        = 4'd5,
    PH_DATA      = 4'd6,
    PH_SKIP_DATA = 4'd7,
    PH_SKIP_HIT  = 4'd8,
    PH_SKIP_END  = 4'd9
  } phase_t;

endpackage

/* rtl/hpwp_in_if.sv */
// ----------------------------------------------------------------------------
// hpwp_in_if
// Packet word channel: valid/ready with the word and a restart flag.
// ----------------------------------------------------------------------------
interface hpwp_in_if;
  logic                         valid;
  logic                         ready;
  logic [hpwp_pkg::WORD_W-1:0]  word;
  logic                         restart;

  modport source (output valid, output word, output restart, input ready);
  modport sink   (input valid, input word, input restart, output ready);
endinterface

/* rtl/hpwp_out_if.sv */
// ----------------------------------------------------------------------------
// hpwp_out_if
// Result channel: waveform points and event end status, valid/ready.
// ----------------------------------------------------------------------------
interface hpwp_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [hpwp_pkg::CHANNEL_W-1:0]  channel;
  logic [hpwp_pkg::LEVEL_W-1:0]    zero_level;
  logic [hpwp_pkg::LEVEL_W-1:0]    charge;
  logic [hpwp_pkg::INDEX_W-1:0]    hit_index;
  logic [hpwp_pkg::INDEX_W-1:0]    point_index;
  logic [hpwp_pkg::VALUE_W-1:0]    point_value;
  logic [hpwp_pkg::WORD_W-1:0]     microslice;
  logic [hpwp_pkg::TIME_W-1:0]     adc_time;
  logic [hpwp_pkg::VERSION_W-1:0]  packet_version;
  logic [hpwp_pkg::STATUS_W-1:0]   status;
  logic                            last;

  modport source (
    output valid, output kind, output channel, output zero_level, output charge,
    output hit_index, output point_index, output point_value, output microslice,
    output adc_time, output packet_version, output status, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input channel, input zero_level, input charge,
    input hit_index, input point_index, input point_value, input microslice,
    input adc_time, input packet_version, input status, input last,
    output ready
  );
endinterface

/* rtl/hit_packet_word_parser_unit.sv */
// ----------------------------------------------------------------------------
// hit_packet_word_parser_unit
// Word-serial parser of detector event packets: header, hits, waveform points.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | transaction
//  in_ch   | in  | valid / ready   | one 64-bit packet word plus restart flag
//  out_ch  | out | valid / ready   | one waveform point or one event status
//
//  A word is parsed in the cycle it is taken; its results (up to
//  64/POINT_BITS points plus one status) sit in a result group register and
//  leave one per cycle while out_ch is ready. A new word is taken while the
//  last result of the group is taken, so words without results, or with
//  one result while out_ch is ready, flow at one per cycle; a word with n
//  results holds intake until its last result is taken. Reset is synchronous,
//  active low, and clears the phase, the event state and the group.
//  Output stalls hold the group and stop intake.
// ----------------------------------------------------------------------------
module hit_packet_word_parser_unit #(
  parameter int HIT_COUNT_BITS = hpwp_pkg::DEF_HIT_COUNT_BITS,
  parameter int MAGIC_BITS     = hpwp_pkg::DEF_MAGIC_BITS,
  parameter int TIME_BITS      = hpwp_pkg::DEF_TIME_BITS,
  parameter int LEVEL_BITS     = hpwp_pkg::DEF_LEVEL_BITS,
  parameter int CHANNEL_BITS   = hpwp_pkg::DEF_CHANNEL_BITS,
  parameter int POINT_BITS     = hpwp_pkg::DEF_POINT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  hpwp_in_if.sink     in_ch,
  hpwp_out_if.source  out_ch
);

  localparam int PER    = hpwp_pkg::WORD_W / POINT_BITS;
  localparam int IDX_W  = $clog2(PER + 1);
  localparam int PSEL_W = $clog2(PER);
  localparam int CW     = hpwp_pkg::COUNT_W;

  hpwp_pkg::phase_t phase_r, phase_nxt, ph;

  logic [hpwp_pkg::WORD_W-1:0] microslice_r, microslice_nxt;
  logic [HIT_COUNT_BITS-1:0]   hits_exp_r, hits_exp_nxt;
  logic [HIT_COUNT_BITS-1:0]   hits_done_r, hits_done_nxt, hits_inc;
  logic [MAGIC_BITS-1:0]       magic_r, magic_nxt, magic2;
  logic [TIME_BITS-1:0]        time_r, time_nxt;
  logic [hpwp_pkg::VERSION_W-1:0] version_r, version_nxt;
  logic [LEVEL_BITS-1:0]       level_r, level_nxt, charge_r, charge_nxt;
  logic [CHANNEL_BITS-1:0]     channel_r, channel_nxt;
  logic [CW-1:0]               pexp_r, pexp_nxt, pdone_r, pdone_nxt;
  logic [CW-1:0]               remaining, pdone_sum, word_count;

  // result group
  logic                        grp_valid_r;
  logic [IDX_W-1:0]            idx_r;
  logic [hpwp_pkg::WORD_W-1:0] grp_word_r;
  logic [IDX_W-1:0]            grp_npts_r, npts_new;
  logic [CW-1:0]               grp_pbase_r;
  logic [CW-1:0]               grp_hit_r, pt_hit_new;
  logic                        grp_stat_r, stat_new;
  logic [hpwp_pkg::STATUS_W-1:0] grp_status_r, status_new;

  logic w3_end, hb_zero, data_done;
  logic in_fire, out_fire, is_stat, is_last;
  logic [IDX_W:0] total;

  logic [POINT_BITS-1:0] pts [2**PSEL_W];
  logic [POINT_BITS-1:0] pt_sel;

  logic [HIT_COUNT_BITS+CW-1:0]                     hits_ext, hits_inc_ext;
  logic [POINT_BITS+hpwp_pkg::VALUE_W-1:0]          pt_ext;
  logic [CHANNEL_BITS+hpwp_pkg::CHANNEL_W-1:0]      chan_ext;
  logic [LEVEL_BITS+hpwp_pkg::LEVEL_W-1:0]          level_ext, charge_ext;
  logic [TIME_BITS+hpwp_pkg::TIME_W-1:0]            time_ext;

  assign ph = in_ch.restart ? hpwp_pkg::PH_W0 : phase_r;

  assign hits_ext     = {{CW{1'b0}}, hits_done_r};
  assign hits_inc     = hits_done_r + HIT_COUNT_BITS'(1);
  assign hits_inc_ext = {{CW{1'b0}}, hits_inc};
  assign word_count   = in_ch.word[CHANNEL_BITS +: CW];
  assign magic2       = in_ch.word[hpwp_pkg::VERSION_W +: MAGIC_BITS];
  assign remaining    = pexp_r - pdone_r;

  // field extraction and result group contents
  always_comb begin
    microslice_nxt = microslice_r;
    hits_exp_nxt   = hits_exp_r;
    hits_done_nxt  = hits_done_r;
    magic_nxt      = magic_r;
    time_nxt       = time_r;
    version_nxt    = version_r;
    level_nxt      = level_r;
    charge_nxt     = charge_r;
    channel_nxt    = channel_r;
    pexp_nxt       = pexp_r;
    pdone_nxt      = pdone_r;
    npts_new       = '0;
    stat_new       = 1'b0;
    status_new     = hpwp_pkg::STATUS_GOOD;
    pt_hit_new     = hits_ext[CW-1:0];
    pdone_sum      = pdone_r;
    w3_end         = 1'b0;
    hb_zero        = 1'b0;
    data_done      = 1'b0;
    case (ph)
      hpwp_pkg::PH_W0: begin
        microslice_nxt = in_ch.word;
      end
      hpwp_pkg::PH_W1: begin
        hits_exp_nxt = in_ch.word[HIT_COUNT_BITS-1:0];
        magic_nxt    = in_ch.word[HIT_COUNT_BITS +: MAGIC_BITS];
      end
      hpwp_pkg::PH_W2: begin
        time_nxt = in_ch.word[TIME_BITS-1:0];
      end
      hpwp_pkg::PH_W3: begin
        version_nxt   = in_ch.word[hpwp_pkg::VERSION_W-1:0];
        hits_done_nxt = '0;
        if (magic_r != MAGIC_BITS'(hpwp_pkg::MAGIC_FIRST) ||
            magic2 != MAGIC_BITS'(hpwp_pkg::MAGIC_SECOND)) begin
          stat_new   = 1'b1;
          status_new = hpwp_pkg::STATUS_BAD_MAGIC;
          w3_end     = 1'b1;
        end else if (hits_exp_r == '0) begin
          stat_new = 1'b1;
          w3_end   = 1'b1;
        end
      end
      hpwp_pkg::PH_HA: begin
        level_nxt  = in_ch.word[LEVEL_BITS-1:0];
        charge_nxt = in_ch.word[LEVEL_BITS +: LEVEL_BITS];
      end
      hpwp_pkg::PH_HB: begin
        channel_nxt = in_ch.word[CHANNEL_BITS-1:0];
        pexp_nxt    = word_count;
        pdone_nxt   = '0;
        if (word_count == '0) begin
          hits_done_nxt = hits_inc;
          stat_new      = 1'b1;
          status_new    = hpwp_pkg::STATUS_BAD_COUNT;
          hb_zero       = 1'b1;
        end
      end
      hpwp_pkg::PH_DATA: begin
        npts_new  = (remaining >= CW'(PER)) ? IDX_W'(PER) : remaining[IDX_W-1:0];
        pdone_sum = pdone_r + CW'(npts_new);
        pdone_nxt = pdone_sum;
        if (pdone_sum >= pexp_r) begin
          data_done     = 1'b1;
          hits_done_nxt = hits_inc;
          if (pexp_r != CW'(hpwp_pkg::GOOD_POINTS)) begin
            stat_new   = 1'b1;
            status_new = hpwp_pkg::STATUS_BAD_COUNT;
          end else if (hits_inc >= hits_exp_r) begin
            stat_new = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // phase sequencing
  always_comb begin
    unique case (ph)
      hpwp_pkg::PH_W0:        phase_nxt = hpwp_pkg::PH_W1;
      hpwp_pkg::PH_W1:        phase_nxt = hpwp_pkg::PH_W2;
      hpwp_pkg::PH_W2:        phase_nxt = hpwp_pkg::PH_W3;
      hpwp_pkg::PH_W3:        phase_nxt = w3_end ? hpwp_pkg::PH_W0 : hpwp_pkg::PH_HA;
      hpwp_pkg::PH_HA:        phase_nxt = hpwp_pkg::PH_HB;
      hpwp_pkg::PH_HB:        phase_nxt = hb_zero ? hpwp_pkg::PH_W0 : hpwp_pkg::PH_DATA;
      hpwp_pkg::PH_DATA: begin
        if (!data_done)     phase_nxt = hpwp_pkg::PH_SKIP_DATA;
        else if (stat_new)  phase_nxt = hpwp_pkg::PH_SKIP_END;
        else                phase_nxt = hpwp_pkg::PH_SKIP_HIT;
      end
      hpwp_pkg::PH_SKIP_DATA: phase_nxt = hpwp_pkg::PH_DATA;
      hpwp_pkg::PH_SKIP_HIT:  phase_nxt = hpwp_pkg::PH_HA;
      hpwp_pkg::PH_SKIP_END:  phase_nxt = hpwp_pkg::PH_W0;
      default:                phase_nxt = hpwp_pkg::PH_W0;
    endcase
  end

  // result group drain
  assign total   = {1'b0, grp_npts_r} + (IDX_W+1)'(grp_stat_r);
  assign is_stat = (idx_r == grp_npts_r);
  assign is_last = ({1'b0, idx_r} + (IDX_W+1)'(1)) == total;

  assign in_ch.ready = !grp_valid_r || (out_ch.ready && is_last);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hpwp_pkg::PH_W0;
      grp_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        grp_valid_r <= (npts_new != '0) || stat_new;
        idx_r       <= '0;
      end else if (out_fire) begin
        if (is_last) begin
          grp_valid_r <= 1'b0;
        end
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      microslice_r <= '0;
      hits_exp_r   <= '0;
      hits_done_r  <= '0;
      magic_r      <= '0;
      time_r       <= '0;
      version_r    <= '0;
      level_r      <= '0;
      charge_r     <= '0;
      channel_r    <= '0;
      pexp_r       <= '0;
      pdone_r      <= '0;
    end else if (in_fire) begin
      microslice_r <= microslice_nxt;
      hits_exp_r   <= hits_exp_nxt;
      hits_done_r  <= hits_done_nxt;
      magic_r      <= magic_nxt;
      time_r       <= time_nxt;
      version_r    <= version_nxt;
      level_r      <= level_nxt;
      charge_r     <= charge_nxt;
      channel_r    <= channel_nxt;
      pexp_r       <= pexp_nxt;
      pdone_r      <= pdone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      grp_word_r   <= in_ch.word;
      grp_npts_r   <= npts_new;
      grp_pbase_r  <= pdone_r;
      grp_hit_r    <= pt_hit_new;
      grp_stat_r   <= stat_new;
      grp_status_r <= status_new;
    end
  end

  // point slots, most significant first
  always_comb begin
    for (int k = 0; k < 2**PSEL_W; k++) begin
      if (k < PER) begin
        pts[k] = grp_word_r[hpwp_pkg::WORD_W - (k + 1) * POINT_BITS +: POINT_BITS];
      end else begin
        pts[k] = '0;
      end
    end
  end

  assign pt_sel     = pts[idx_r[PSEL_W-1:0]];
  assign pt_ext     = {{hpwp_pkg::VALUE_W{1'b0}}, pt_sel};
  assign chan_ext   = {{hpwp_pkg::CHANNEL_W{1'b0}}, channel_r};
  assign level_ext  = {{hpwp_pkg::LEVEL_W{1'b0}}, level_r};
  assign charge_ext = {{hpwp_pkg::LEVEL_W{1'b0}}, charge_r};
  assign time_ext   = {{hpwp_pkg::TIME_W{1'b0}}, time_r};

  assign out_ch.valid          = grp_valid_r;
  assign out_ch.kind           = is_stat ? hpwp_pkg::KIND_STATUS : hpwp_pkg::KIND_POINT;
  assign out_ch.channel        = is_stat ? '0 : chan_ext[hpwp_pkg::CHANNEL_W-1:0];
  assign out_ch.zero_level     = is_stat ? '0 : level_ext[hpwp_pkg::LEVEL_W-1:0];
  assign out_ch.charge         = is_stat ? '0 : charge_ext[hpwp_pkg::LEVEL_W-1:0];
  assign out_ch.hit_index      = is_stat ? hits_ext[CW-1:0] : grp_hit_r;
  assign out_ch.point_index    = is_stat ? '0 : grp_pbase_r + CW'(idx_r);
  assign out_ch.point_value    = is_stat ? '0 : pt_ext[hpwp_pkg::VALUE_W-1:0];
  assign out_ch.microslice     = microslice_r;
  assign out_ch.adc_time       = time_ext[hpwp_pkg::TIME_W-1:0];
  assign out_ch.packet_version = version_r;
  assign out_ch.status         = is_stat ? grp_status_r : hpwp_pkg::STATUS_GOOD;
  assign out_ch.last           = is_last;

endmodule

/* rtl/hpwp_checker.sv */
// ----------------------------------------------------------------------------
// hpwp_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module hpwp_checker (
  input  logic        clk,
  input  logic        rst_n,
  hpwp_in_if.sink     in_ch,
  hpwp_out_if.source  out_ch
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.kind) &&
      $stable(out_ch.point_value) && $stable(out_ch.status) && $stable(out_ch.last))
    else $error("result changed while stalled");

  // event status always closes the word's results
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == hpwp_pkg::KIND_STATUS |-> out_ch.last)
    else $error("status transaction not last");

  a_point_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == hpwp_pkg::KIND_POINT |->
      out_ch.status == hpwp_pkg::STATUS_GOOD)
    else $error("point transaction with nonzero status");

  a_stat_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == hpwp_pkg::KIND_STATUS |->
      out_ch.point_value == '0 && out_ch.channel == '0 && out_ch.point_index == '0)
    else $error("status transaction carries hit data");

  // intake waits while a non-final result is pending
  a_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> !in_ch.ready)
    else $error("word taken while results pending");

endmodule

bind hit_packet_word_parser_unit hpwp_checker u_hpwp_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
